### rtl/core/isp_pkg.sv
package isp_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_AXIS_MODE     = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SHEAR_COEF    = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_LEFT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_TOP    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_LEFT   = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_OUTPUT_TOP    = 3'd7;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_READ = 1'b1;
	localparam logic AXIS_X    = 1'b0;
	localparam logic AXIS_Y    = 1'b1;

	// coordinate widths: far axis after the 24-bit fraction drop plus offset
	localparam int unsigned COORD_W = 23;
	localparam int unsigned NEAR_W  = 18;

	typedef struct packed {
		logic               axis_mode;
		logic signed [17:0] shear_coefficient;
		logic signed [23:0] source_left;
		logic signed [23:0] source_top;
		logic        [8:0]  source_width;
		logic        [8:0]  source_height;
		logic signed [15:0] output_left;
		logic signed [15:0] output_top;
	} cfg_t;

endpackage

### rtl/core/image_shear_pass.sv
// Nearest-neighbor shear pass over an 8-bit alpha frame store.
// Input channel (in_valid/in_ready): kind 0 loads pixel_in at (column, row)
// of the store, kind 1 reads output pixel (column, row) relative to the
// output bounds corner. Only reads produce a transaction on the output
// channel (out_valid/out_ready), carrying pixel_value and covered, in order.
// Config channel (cfg_valid/cfg_ready): cfg_index picks the register,
// cfg_data holds the value; always ready, write only while idle.
// Throughput: one item per cycle unless the receiver stalls. Four register
// stages: three arithmetic stages (mapping, Q1.16 multiply, wide subtract
// with floor) and the store read with its registered port. The accepting
// edge fills the first stage; a read's result then passes the multiply,
// subtract and store-read registers. Loads travel the same stages and write
// the store where reads sample it, so a read sees exactly the loads
// accepted before it. Reset clears config to its defaults and empties the
// pipeline; the store is not cleared. When the receiver stalls the whole
// pipeline holds and in_ready drops until the output transaction is taken.
module image_shear_pass import isp_pkg::*; #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   kind,
	input  logic [11:0]            column,
	input  logic [11:0]            row,
	input  logic [7:0]             pixel_in,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             pixel_value,
	output logic                   covered,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned CW    = $clog2(MAX_WIDTH);
	localparam int unsigned RW    = $clog2(MAX_HEIGHT);

	cfg_t cfg_q;

	logic advance;
	logic accept;
	logic load_we;
	logic [AW-1:0] load_addr;
	logic load_s1, load_s2, load_s3;
	logic [AW-1:0] load_addr_s1, load_addr_s2, load_addr_s3;
	logic [7:0] load_pixel_s1, load_pixel_s2, load_pixel_s3;

	logic valid_s3;
	logic signed [COORD_W-1:0] far_s3;
	logic signed [NEAR_W-1:0]  near_s3;

	logic signed [COORD_W-1:0] sx, sy;
	logic cov;
	logic [AW-1:0] read_addr;
	logic valid_s4, covered_s4;
	logic [7:0] rdata;

	// a single stall signal freezes every stage together
	assign advance   = !valid_s4 || out_ready;
	assign in_ready  = advance;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_mode         <= AXIS_X;
			cfg_q.shear_coefficient <= '0;
			cfg_q.source_left       <= '0;
			cfg_q.source_top        <= '0;
			cfg_q.source_width      <= 9'd256;
			cfg_q.source_height     <= 9'd256;
			cfg_q.output_left       <= '0;
			cfg_q.output_top        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_AXIS_MODE:     cfg_q.axis_mode         <= cfg_data[0];
				REG_SHEAR_COEF:    cfg_q.shear_coefficient <= cfg_data[17:0];
				REG_SOURCE_LEFT:   cfg_q.source_left       <= cfg_data;
				REG_SOURCE_TOP:    cfg_q.source_top        <= cfg_data;
				REG_SOURCE_WIDTH:  cfg_q.source_width      <= cfg_data[8:0];
				REG_SOURCE_HEIGHT: cfg_q.source_height     <= cfg_data[8:0];
				REG_OUTPUT_LEFT:   cfg_q.output_left       <= cfg_data[15:0];
				REG_OUTPUT_TOP:    cfg_q.output_top        <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// drop loads that fall outside the store
	assign load_we = accept && (kind == KIND_LOAD)
		&& ({1'b0, column} < 13'(MAX_WIDTH))
		&& ({1'b0, row} < 13'(MAX_HEIGHT));
	assign load_addr = AW'(row[RW-1:0]) * AW'(MAX_WIDTH) + AW'(column[CW-1:0]);

	// carry loads down with the reads so both reach the store at the same
	// stage and hit it in arrival order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_s1 <= 1'b0;
			load_s2 <= 1'b0;
			load_s3 <= 1'b0;
		end else if (advance) begin
			load_s1 <= load_we;
			load_s2 <= load_s1;
			load_s3 <= load_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			load_addr_s1  <= load_addr;
			load_addr_s2  <= load_addr_s1;
			load_addr_s3  <= load_addr_s2;
			load_pixel_s1 <= pixel_in;
			load_pixel_s2 <= load_pixel_s1;
			load_pixel_s3 <= load_pixel_s2;
		end
	end

	isp_map u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.cfg      (cfg_q),
		.start    (accept && (kind == KIND_READ)),
		.column   (column),
		.row      (row),
		.valid_s3 (valid_s3),
		.far_s3   (far_s3),
		.near_s3  (near_s3)
	);

	// pick axes, check coverage against the saturated source size
	always_comb begin
		if (cfg_q.axis_mode == AXIS_X) begin
			sx = far_s3;
			sy = COORD_W'(near_s3);
		end else begin
			sx = COORD_W'(near_s3);
			sy = far_s3;
		end
		cov = (sx >= 0) && (sy >= 0)
			&& (sx < $signed({14'd0, cfg_q.source_width}))
			&& (sy < $signed({14'd0, cfg_q.source_height}))
			&& (sx < $signed(COORD_W'(MAX_WIDTH)))
			&& (sy < $signed(COORD_W'(MAX_HEIGHT)));
		read_addr = cov ? AW'(sy[RW-1:0]) * AW'(MAX_WIDTH) + AW'(sx[CW-1:0]) : '0;
	end

	isp_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (load_s3 && advance),
		.waddr (load_addr_s3),
		.wdata (load_pixel_s3),
		.re    (advance),
		.raddr (read_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			covered_s4 <= cov;
		end
	end

	assign out_valid   = valid_s4;
	assign covered     = covered_s4;
	assign pixel_value = covered_s4 ? rdata : 8'd0;

endmodule

### rtl/core/isp_ram.sv
module isp_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/core/isp_map.sv
module isp_map import isp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  cfg_t                      cfg,
	input  logic                      start,
	input  logic [11:0]               column,
	input  logic [11:0]               row,
	output logic                      valid_s3,
	output logic signed [COORD_W-1:0] far_s3,
	output logic signed [NEAR_W-1:0]  near_s3
);

	logic                valid_s1, valid_s2;
	logic signed [16:0]  along_s1;
	logic [11:0]         offset_s1, offset_s2;
	logic signed [42:0]  prod_s2;
	logic signed [NEAR_W-1:0] near_s2;

	logic signed [16:0]  along_next;
	logic [11:0]         offset_next;
	logic signed [24:0]  along8;
	logic signed [23:0]  src_along, src_across;
	logic signed [15:0]  across_base;
	logic signed [24:0]  across8;
	logic signed [25:0]  near_diff;
	logic signed [45:0]  base;
	logic signed [45:0]  start24;
	logic signed [COORD_W-1:0] far_next;

	always_comb begin
		if (cfg.axis_mode == AXIS_X) begin
			along_next  = 17'(cfg.output_top) + $signed({5'd0, row});
			offset_next = column;
			src_along   = cfg.source_top;
			src_across  = cfg.source_left;
			across_base = cfg.output_left;
		end else begin
			along_next  = 17'(cfg.output_left) + $signed({5'd0, column});
			offset_next = row;
			src_along   = cfg.source_left;
			src_across  = cfg.source_top;
			across_base = cfg.output_top;
		end
		along8    = $signed({along_s1, 8'h80});
		near_diff = 26'(along8) - 26'(src_along);
		across8   = $signed({across_base, 8'h80});
		// the user must keep config put while items are in flight (the block does not enforce it), so this term is static
		base      = (46'(across8) - 46'(src_across)) <<< 16;
		start24   = base - 46'(prod_s2);
		far_next  = COORD_W'($signed(start24[45:24]))
			+ COORD_W'($signed({11'd0, offset_s2}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			along_s1  <= along_next;
			offset_s1 <= offset_next;
			prod_s2   <= 43'(cfg.shear_coefficient) * 43'(along8);
			near_s2   <= near_diff[25:8];
			offset_s2 <= offset_s1;
			far_s3    <= far_next;
			near_s3   <= near_s2;
		end
	end

endmodule
